// ===== src/csb_pkg.sv =====
// Shared types, codes and helpers for the counting semaphore bank.
// Depends on nothing; imported by every module of the block.
package csb_pkg;

  localparam int unsigned NumSlotsDefault = 64;

  // Request modes
  localparam logic [1:0] MODE_CREATE = 2'd0;
  localparam logic [1:0] MODE_DOWN   = 2'd1;
  localparam logic [1:0] MODE_UP     = 2'd2;
  localparam logic [1:0] MODE_FREE   = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_ERR     = 2'd1;
  localparam logic [1:0] STAT_BLOCKED = 2'd2;

  // One slot's counters as held in the memory
  typedef struct packed {
    logic [15:0] count;
    logic [7:0]  holders;
    logic [7:0]  waiters;
  } entry_t;

  function automatic logic [7:0] inc8(input logic [7:0] v);
    inc8 = (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic logic [7:0] dec8(input logic [7:0] v);
    dec8 = (v == 8'h00) ? v : v - 8'd1;
  endfunction

endpackage

// ===== src/counting_semaphore_bank_unit.sv =====
// Counting semaphore bank: a bank of NUM_SLOTS semaphores with create, down, up
// and free requests; one result per request.
// Channels: input request (mode, sem_id, init_value) and output result (status,
// slot_index, granted), each with valid and stall; a transfer happens on a clock
// edge where valid is high and stall is low.
// Flow: a request is not taken until the one before it has finished its modify
// step. The accept cycle reads the slot's counters from the one-read, one-write
// counter memory; the modify step then changes them, writes them back and loads
// the result register. The next request is taken in the cycle after the
// write-back, so a read never overlaps a pending write.
// Create picks the lowest free slot from the used bits at accept time.
// Stalling: the result register holds while out_stall_i is high; a second
// request may already be read meanwhile, and it then waits in its modify step
// until the result register is free.
// Reset: rst_ni clears used bits, memory written bits and all control state at
// once; entries never written read as zero, so no clearing pass is needed.
module counting_semaphore_bank_unit import csb_pkg::*; #(
  parameter int unsigned NUM_SLOTS = NumSlotsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic signed [7:0]  sem_id_i,
  input  logic signed [15:0] init_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [5:0]         slot_index_o,
  output logic               granted_o
);

  localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  // request held for the modify step
  logic [1:0]    mode_q;
  logic [IW-1:0] id_q;
  logic          id_ok_q;
  logic [15:0]   init_q;
  logic          free_found_q;
  logic [IW-1:0] free_idx_q;

  logic [NUM_SLOTS-1:0] used_q, used_d;

  logic       out_valid_q, out_valid_d;
  logic [1:0] status_q, status_d;
  logic [5:0] slot_q, slot_d;
  logic       granted_q, granted_d;

  logic          accept;
  logic          fire;
  logic          id_ok;
  logic          alloc_found;
  logic [IW-1:0] alloc_idx;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  entry_t        rd_data;
  logic [7:0]    holders_dn;
  logic [6:0]    slot_wide;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  // modify step completes only when the result register can take the result
  assign fire       = (state_q == S_EXEC) && !(out_valid_q && out_stall_i);

  // id names a slot when non-negative and below the bank size
  assign id_ok = !sem_id_i[7] && ({1'b0, sem_id_i[6:0]} < 8'(NUM_SLOTS));

  csb_alloc #(
    .NUM_SLOTS(NUM_SLOTS),
    .IW       (IW)
  ) u_alloc (
    .used_i (used_q),
    .found_o(alloc_found),
    .idx_o  (alloc_idx)
  );

  csb_mem #(
    .NUM_SLOTS(NUM_SLOTS),
    .IW       (IW)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_addr_i(sem_id_i[IW-1:0]),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_data_o(rd_data)
  );

  // capture the request and the free-slot search at accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q       <= mode_i;
      id_q         <= sem_id_i[IW-1:0];
      id_ok_q      <= id_ok;
      init_q       <= init_value_i;
      free_found_q <= alloc_found;
      free_idx_q   <= alloc_idx;
    end
  end

  assign holders_dn = dec8(rd_data.holders);
  assign slot_wide  = 7'(free_idx_q);

  // modify step: decide the result and the write-back
  always_comb begin
    status_d  = STAT_OK;
    slot_d    = '0;
    granted_d = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = id_q;
    wr_data   = rd_data;
    used_d    = used_q;

    case (mode_q)
      MODE_CREATE: begin
        if (init_q[15] || !free_found_q) begin
          status_d = STAT_ERR;
        end else begin
          wr_addr            = free_idx_q;
          wr_data.count      = init_q;
          wr_data.holders    = '0;
          wr_data.waiters    = '0;
          wr_en              = 1'b1;
          used_d[free_idx_q] = 1'b1;
          slot_d             = slot_wide[5:0];
        end
      end
      MODE_DOWN: begin
        if (!id_ok_q || !used_q[id_q]) begin
          status_d = STAT_ERR;
        end else if (rd_data.count == 16'd0) begin
          // no unit left: record a waiter
          wr_data.waiters = inc8(rd_data.waiters);
          wr_en           = 1'b1;
          status_d        = STAT_BLOCKED;
        end else begin
          wr_data.count   = rd_data.count - 16'd1;
          wr_data.holders = inc8(rd_data.holders);
          wr_en           = 1'b1;
        end
      end
      MODE_UP: begin
        // used bit is not checked on up
        if (!id_ok_q) begin
          status_d = STAT_ERR;
        end else begin
          wr_en = 1'b1;
          if (rd_data.waiters != 8'd0) begin
            // hand the unit straight to one waiter
            wr_data.waiters = rd_data.waiters - 8'd1;
            wr_data.holders = inc8(holders_dn);
            granted_d       = 1'b1;
          end else begin
            wr_data.holders = holders_dn;
            if (rd_data.count != 16'hFFFF) begin
              wr_data.count = rd_data.count + 16'd1;
            end
          end
        end
      end
      MODE_FREE: begin
        if (!id_ok_q || rd_data.holders != 8'd0 || rd_data.waiters != 8'd0) begin
          status_d = STAT_ERR;
        end else begin
          used_d[id_q] = 1'b0;
        end
      end
      default: begin
        status_d = STAT_ERR;
      end
    endcase

    // hold everything until the result can be loaded
    if (!fire) begin
      wr_en  = 1'b0;
      used_d = used_q;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result register: load on a completed modify step
  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q  <= status_d;
      slot_q    <= slot_d;
      granted_q <= granted_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign slot_index_o = slot_q;
  assign granted_o    = granted_q;

endmodule

// ===== src/csb_mem.sv =====
// Counter memory of the semaphore bank: one entry per slot, registered read.
// Depends on csb_pkg. A per-entry written bit makes unwritten entries read as zero.
module csb_mem import csb_pkg::*; #(
  parameter int unsigned NUM_SLOTS = NumSlotsDefault,
  parameter int unsigned IW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [IW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic [IW-1:0] wr_addr_i,
  input  entry_t        wr_data_i,
  output entry_t        rd_data_o
);

  entry_t                 mem [NUM_SLOTS];
  logic   [NUM_SLOTS-1:0] written_q;
  entry_t                 rd_q;
  logic                   rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q  <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        written_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= written_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : '0;

endmodule

// ===== src/csb_alloc.sv =====
// Free-slot finder: lowest slot whose used bit is clear.
// Depends on csb_pkg for the default bank size.
module csb_alloc import csb_pkg::*; #(
  parameter int unsigned NUM_SLOTS = NumSlotsDefault,
  parameter int unsigned IW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic [NUM_SLOTS-1:0] used_i,
  output logic                 found_o,
  output logic [IW-1:0]        idx_o
);

  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    // scan downward so the lowest free slot wins
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used_i[i]) begin
        found_o = 1'b1;
        idx_o   = IW'(i);
      end
    end
  end

endmodule

// ===== tb/counting_semaphore_bank_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for counting_semaphore_bank_unit: directed, full-bank,
// saturation, hold-off and random request traffic checked against an in-bench bank predictor.
// Depends on csb_pkg for the mode and status codes and on the unit's RTL.
module counting_semaphore_bank_unit_tb;
  import csb_pkg::*;

  localparam int NUM_SLOTS       = NumSlotsDefault;
  localparam int HOLD_OFF_CYCLES = 64;    // long receiver hold-off to fill the block
  localparam int QUIET_LIMIT     = 2000;  // cycles with no transfer before giving up
  localparam int DRAIN_CYCLES    = 16;    // settle time after the last result
  localparam int REPORT_LIMIT    = 10;    // mismatches printed in full

  // Result fields in the order the unit presents them
  typedef struct packed {
    logic [1:0] status;
    logic [5:0] slot_index;
    logic       granted;
  } sem_result_t;

  // DUT ports; every input starts at a known value
  logic               clk_i;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic [1:0]         mode_i       = MODE_CREATE;
  logic signed [7:0]  sem_id_i     = '0;
  logic signed [15:0] init_value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic [1:0]         status_o;
  logic [5:0]         slot_index_o;
  logic               granted_o;

  // Predicted bank contents, cleared as at reset
  bit          sem_used    [NUM_SLOTS];
  bit [15:0]   sem_count   [NUM_SLOTS];
  bit [7:0]    sem_holders [NUM_SLOTS];
  bit [7:0]    sem_waiters [NUM_SLOTS];

  sem_result_t pending_results[$];  // predicted results not yet seen at the output
  sem_result_t last_prediction;     // result of the most recently accepted request

  int send_idle_pct = 0;  // chance, in percent, of an idle cycle before a request
  int recv_idle_pct = 0;  // chance, in percent, of stalling the output in a cycle
  bit hold_toggle   = 1'b0;  // flip to start one long output hold-off

  int requests_sent   = 0;
  int results_checked = 0;
  int blocked_seen    = 0;
  int granted_seen    = 0;
  int mismatch_count  = 0;

  counting_semaphore_bank_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .sem_id_i    (sem_id_i),
    .init_value_i(init_value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .slot_index_o(slot_index_o),
    .granted_o   (granted_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Apply one request to the predicted bank and return the result it must give.
  function automatic sem_result_t semaphore_bank_apply(input logic [1:0] mode,
                                                       input logic signed [7:0] id,
                                                       input logic [15:0] initv);
    sem_result_t r;
    int          slot;
    bit          placed;
    r      = '{status: STAT_OK, slot_index: 6'd0, granted: 1'b0};
    slot   = int'(id);
    placed = 1'b0;
    if (mode == MODE_CREATE) begin
      // A negative start count is refused; otherwise take the lowest free slot.
      r.status = STAT_ERR;
      if (!initv[15]) begin
        for (int i = 0; i < NUM_SLOTS && !placed; i++) begin
          if (!sem_used[i]) begin
            sem_used[i]    = 1'b1;
            sem_count[i]   = initv;
            sem_holders[i] = '0;
            sem_waiters[i] = '0;
            r.status       = STAT_OK;
            r.slot_index   = 6'(i);
            placed         = 1'b1;
          end
        end
      end
    end else if (slot < 0 || slot >= NUM_SLOTS) begin
      r.status = STAT_ERR;
    end else if (mode == MODE_DOWN) begin
      if (!sem_used[slot]) begin
        r.status = STAT_ERR;
      end else if (sem_count[slot] == 16'd0) begin
        if (sem_waiters[slot] != 8'hFF) sem_waiters[slot]++;
        r.status = STAT_BLOCKED;
      end else begin
        sem_count[slot]--;
        if (sem_holders[slot] != 8'hFF) sem_holders[slot]++;
      end
    end else if (mode == MODE_UP) begin
      // The used mark is not consulted: up works on any slot's counters.
      if (sem_holders[slot] != 8'd0) sem_holders[slot]--;
      if (sem_waiters[slot] != 8'd0) begin
        // Hand the unit straight to a waiter, who becomes a holder.
        sem_waiters[slot]--;
        if (sem_holders[slot] != 8'hFF) sem_holders[slot]++;
        r.granted = 1'b1;
      end else if (sem_count[slot] != 16'hFFFF) begin
        sem_count[slot]++;
      end
    end else begin
      // Free of a slot that is still in use by holders or waiters is refused.
      if (sem_holders[slot] != 8'd0 || sem_waiters[slot] != 8'd0) r.status = STAT_ERR;
      else sem_used[slot] = 1'b0;
    end
    return r;
  endfunction

  // Offer one request, hold it until it is taken, then predict its result.
  task automatic send_request(input logic [1:0] mode, input int id, input int initv);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    sem_id_i     <= 8'(id);
    init_value_i <= 16'(initv);
    // Values read right after the edge are the ones the edge sampled.
    do @(posedge clk_i); while (in_stall_o);
    last_prediction = semaphore_bank_apply(mode, 8'(id), 16'(initv));
    pending_results.push_back(last_prediction);
    requests_sent++;
  endtask

  // Output side: random stalls, or a long hold-off whenever hold_toggle flips.
  initial begin : result_sink
    int hold_left;
    bit seen_toggle;
    hold_left   = 0;
    seen_toggle = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_toggle != seen_toggle) begin
        seen_toggle = hold_toggle;
        hold_left   = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Compare every result taken from the unit with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    sem_result_t got;
    sem_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{status: status_o, slot_index: slot_index_o, granted: granted_o};
      results_checked++;
      if (got.status == STAT_BLOCKED) blocked_seen++;
      if (got.granted) granted_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result: status %0d slot %0d granted %0d",
                   got.status, got.slot_index, got.granted);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.slot_index !== want.slot_index ||
            got.granted !== want.granted) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display({"result %0d: expected status %0d slot %0d granted %0d, ",
                      "got status %0d slot %0d granted %0d"},
                     results_checked, want.status, want.slot_index, want.granted,
                     got.status, got.slot_index, got.granted);
        end
      end
    end
  end

  // Give up when neither side has moved a request or result for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  // Field extremes, every mode, bad and unused ids, hand-off, free refusal.
  task automatic test_directed_cases();
    send_request(MODE_CREATE, 0, 0);          // slot 0, empty count
    send_request(MODE_CREATE, -1, 32767);     // slot 1, id ignored, largest count
    send_request(MODE_CREATE, 5, -1);         // negative start count
    send_request(MODE_CREATE, 127, -32768);   // most negative start count
    send_request(MODE_DOWN, 0, 0);            // zero count: blocks
    send_request(MODE_DOWN, 1, 0);            // takes a unit
    send_request(MODE_UP, 0, -1);             // hands the unit to the waiter
    send_request(MODE_UP, 1, 32767);          // unit goes back to the count
    send_request(MODE_DOWN, -128, 0);         // bad ids for every mode
    send_request(MODE_DOWN, 127, 0);
    send_request(MODE_DOWN, NUM_SLOTS, 0);
    send_request(MODE_UP, -1, 0);
    send_request(MODE_FREE, NUM_SLOTS, 0);
    send_request(MODE_FREE, -128, 0);
    send_request(MODE_DOWN, 5, 0);            // unused slot refuses down
    send_request(MODE_UP, 6, 0);              // unused slot still counts up
    send_request(MODE_DOWN, 6, 0);            // ... but stays unusable
    send_request(MODE_FREE, 7, 0);            // unused slot frees quietly
    send_request(MODE_FREE, 0, 0);            // holder from the hand-off remains
    send_request(MODE_UP, 0, 0);
    send_request(MODE_FREE, 0, 0);
    send_request(MODE_CREATE, 0, 1);          // reuses slot 0
    send_request(MODE_DOWN, NUM_SLOTS - 1, 0);
  endtask

  // Fill every free slot, try more creates than the bank has room for, then release the whole bank.
  task automatic test_bank_full();
    for (int i = 0; i <= NUM_SLOTS; i++) send_request(MODE_CREATE, i, i % 4);
    for (int i = 0; i < NUM_SLOTS; i++) send_request(MODE_FREE, i, 0);
  endtask

  // Drive the waiter counter into its limit, then hand units to waiters.
  task automatic test_saturation();
    int slot;
    send_request(MODE_CREATE, 0, 0);
    slot = last_prediction.slot_index;
    repeat (258) send_request(MODE_DOWN, slot, 0);   // waiters pin at the top
    repeat (2) send_request(MODE_UP, slot, 0);       // units handed to waiters
    send_request(MODE_FREE, slot, 0);                // refused: waiters remain
  endtask

  // Hold the output off for a long stretch while requests keep coming.
  task automatic test_stall_fill();
    hold_toggle <= ~hold_toggle;
    repeat (20)
      send_request(2'($urandom_range(0, 3)), $urandom_range(0, NUM_SLOTS - 1),
                   $urandom_range(0, 5));
  endtask

  // Mostly well-formed traffic on live slots, with some raw noise mixed in.
  task automatic test_random_traffic(input int items, input int send_pct, input int recv_pct);
    int         used_n;
    int         kind;
    int         slot;
    logic [1:0] mode;
    int         id;
    int         initv;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (items) begin
      used_n = 0;
      foreach (sem_used[i]) used_n += sem_used[i];
      mode  = 2'($urandom_range(0, 3));
      id    = $urandom_range(0, 255);
      initv = $urandom_range(0, 65535);
      if ($urandom_range(0, 99) >= 15) begin
        kind = $urandom_range(0, 99);
        if (used_n == 0 || kind < ((used_n < 6) ? 35 : 10)) begin
          // Small start counts keep blocking and hand-off frequent.
          mode  = MODE_CREATE;
          initv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767)
                                              : $urandom_range(0, 3);
        end else begin
          slot = $urandom_range(0, NUM_SLOTS - 1);
          while (!sem_used[slot]) slot = (slot + 1) % NUM_SLOTS;
          id   = slot;
          mode = (kind < 45) ? MODE_DOWN : (kind < 85) ? MODE_UP : MODE_FREE;
        end
      end
      send_request(mode, id, initv);
    end
  endtask

  initial begin : test_sequence
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 13;
    recv_idle_pct = 49;
    test_directed_cases();
    test_bank_full();
    test_saturation();
    test_stall_fill();

    test_random_traffic(55, 13, 49);
    test_random_traffic(55, 49, 13);
    test_random_traffic(55, 0, 0);

    // Drop valid on the step of the last accept, then wait for the tail.
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d requests and %0d results (%0d blocked, %0d handed off)",
             requests_sent, results_checked, blocked_seen, granted_seen);
    $display({"exercised directed cases, full bank, waiter limit, output hold-off, ",
              "random traffic; %0d mismatches"}, mismatch_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/csb_pkg.sv
src/csb_mem.sv
src/csb_alloc.sv
src/counting_semaphore_bank_unit.sv
tb/counting_semaphore_bank_unit_tb.sv
